FILE: design/hvc_pkg.sv
`timescale 1ns / 1ps

package hvc_pkg;

  localparam int DEF_MAX_WIDTH   = 256;
  localparam int DEF_MAX_DEPTH   = 256;
  localparam int DEF_HEIGHT_BITS = 8;

  localparam logic [8:0] RST_GRID_WIDTH      = 9'd256;
  localparam logic [8:0] RST_GRID_DEPTH      = 9'd256;
  localparam logic [7:0] RST_VERTICAL_LEVELS = 8'd64;
  localparam logic [7:0] RST_WATER_LEVEL     = 8'd16;
  localparam logic       RST_WATER_ENABLED   = 1'b1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH      = 3'd0,
    CFG_GRID_DEPTH      = 3'd1,
    CFG_VERTICAL_LEVELS = 3'd2,
    CFG_WATER_LEVEL     = 3'd3,
    CFG_WATER_ENABLED   = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MAT_AIR     = 3'd0,
    MAT_BEDROCK = 3'd1,
    MAT_STONE   = 3'd2,
    MAT_DIRT    = 3'd3,
    MAT_GRASS   = 3'd4,
    MAT_SAND    = 3'd5,
    MAT_SNOW    = 3'd6,
    MAT_WATER   = 3'd7
  } mat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RD_C,
    ST_RD_W,
    ST_RD_E,
    ST_RD_N,
    ST_RD_S,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic        operation;
    logic [7:0]  col_x;
    logic [7:0]  col_z;
    logic [7:0]  level_y;
    logic [16:0] elevation;
  } item_t;

  typedef struct packed {
    logic [2:0] material;
    logic [7:0] surface_height;
    logic [7:0] water_top;
    logic       steep;
    logic [7:0] highest_ground;
    logic       inside_grid;
  } result_t;

  typedef struct packed {
    logic [7:0] height;
    logic [7:0] level_y;
    logic [7:0] vertical_levels;
    logic [7:0] water_level;
    logic       water_enabled;
    logic       steep;
  } cls_in_t;

endpackage

FILE: design/hvc_height_mem.sv
`timescale 1ns / 1ps

module hvc_height_mem #(
  parameter int AW = 16,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/hvc_quantize.sv
`timescale 1ns / 1ps

module hvc_quantize #(
  parameter int HEIGHT_BITS = 8
) (
  input  logic        clk,
  input  logic        capture,
  input  logic [16:0] elevation,
  input  logic [7:0]  vertical_levels,
  input  logic [7:0]  water_level,
  output logic [7:0]  height
);

  localparam int HeightMax = (2 ** HEIGHT_BITS) - 1;

  logic [7:0]  scale;
  logic [24:0] prod;
  logic [25:0] rounded;
  logic [9:0]  q;
  logic [8:0]  lim;
  logic [8:0]  lim_cap;

  assign scale = (vertical_levels != 8'd0) ? vertical_levels - 8'd1 : 8'd0;

  always_ff @(posedge clk) begin
    if (capture) begin
      prod <= elevation * scale;
    end
  end

  always_comb begin
    rounded = 26'(prod) + 26'd32768;
    q       = rounded[25:16];
    lim     = ((vertical_levels > water_level) ? {1'b0, vertical_levels}
                                               : {1'b0, water_level}) + 9'd2;
    lim_cap = (32'(lim) > HeightMax) ? 9'(HeightMax) : lim;
    height  = (q > 10'(lim_cap)) ? 8'(lim_cap) : 8'(q);
  end

endmodule

FILE: design/hvc_classify.sv
`timescale 1ns / 1ps

module hvc_classify (
  input  hvc_pkg::cls_in_t cls,
  output logic [2:0]       material
);

  import hvc_pkg::*;

  logic [12:0] snow_lhs, snow_rhs;
  logic [11:0] rock_lhs, rock_rhs;
  logic [8:0]  y_plus;

  always_comb begin
    snow_lhs = 13'(cls.height) * 13'd25;
    snow_rhs = 13'(cls.vertical_levels) * 13'd22;
    rock_lhs = 12'(cls.height) * 12'd10;
    rock_rhs = 12'(cls.vertical_levels) * 12'd7;
    y_plus   = {1'b0, cls.level_y} + 9'd3;
    if (cls.level_y <= cls.height) begin
      if (cls.level_y == 8'd0) begin
        material = MAT_BEDROCK;
      end else if (y_plus < {1'b0, cls.height}) begin
        material = MAT_STONE;
      end else if (cls.level_y < cls.height) begin
        material = MAT_DIRT;
      end else if (cls.height <= cls.water_level) begin
        material = MAT_SAND;
      end else if (snow_lhs >= snow_rhs) begin
        material = MAT_SNOW;
      end else if (cls.steep || rock_lhs >= rock_rhs) begin
        material = MAT_STONE;
      end else begin
        material = MAT_GRASS;
      end
    end else if (cls.water_enabled && cls.height < cls.water_level &&
                 cls.level_y <= cls.water_level) begin
      material = MAT_WATER;
    end else begin
      material = MAT_AIR;
    end
  end

endmodule

FILE: design/heightmap_voxel_classifier.sv
`timescale 1ns / 1ps

// heightmap voxel classifier
// item channel (item_valid / item_stall / item_word): a load word quantizes an
//   elevation and stores it for its column; a query word asks for the material
//   of one voxel. one item is worked on at a time; item_stall is high from the
//   accepting edge until its result is placed in the output register.
// result channel (result_valid / result_stall / result_word): one word per item,
//   held in an output register, so the next item is taken while it waits.
// load: the elevation is multiplied as the item is accepted, then the load step
//   clamps the height and writes it; the done step then places the result.
// query inside the grid: five read steps (own column and four neighbors) on one
//   memory read port, then an evaluation step, then the done step.
// query outside the grid: goes straight from accept to the done step.
// a stalled result holds its word; a finished item then waits in the last step
//   until the output register is free, and no new item is taken meanwhile.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; the
//   user is to write it only while idle, which the block itself does not enforce.
// reset (rst, synchronous): registers go to their defaults, the running maximum
//   clears, no result is pending. the height memory is not cleared; a column
//   must be loaded before a query touches it.

module heightmap_voxel_classifier #(
  parameter int MAX_WIDTH   = hvc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_DEPTH   = hvc_pkg::DEF_MAX_DEPTH,
  parameter int HEIGHT_BITS = hvc_pkg::DEF_HEIGHT_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  hvc_pkg::item_t   item_word,
  output logic             result_valid,
  input  logic             result_stall,
  output hvc_pkg::result_t result_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [2:0]       cfg_index,
  input  logic [8:0]       cfg_data
);

  import hvc_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int ZW = $clog2(MAX_DEPTH);
  localparam int AW = XW + ZW;

  state_t state, state_next;

  logic [8:0] grid_width, grid_depth;
  logic [7:0] vertical_levels, water_level;
  logic       water_enabled;

  logic       op_reg, inside_reg, steep_reg;
  logic [7:0] x_reg, z_reg, y_reg, g_reg, max_height;

  logic [8:0] lim_w, lim_d;
  logic       inside_now, accept, result_load;
  logic       has_w, has_e, has_n, has_s, nb_steep;

  logic [XW-1:0]          xa;
  logic [ZW-1:0]          za;
  logic [AW-1:0]          mem_raddr;
  logic                   mem_we;
  logic [HEIGHT_BITS-1:0] mem_rdata;
  logic [7:0]             nb_height, q_height, top, diff;
  logic [2:0]             cls_material;
  cls_in_t                cls;

  assign cfg_ready = 1'b1;

  assign lim_w = (32'(grid_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : grid_width;
  assign lim_d = (32'(grid_depth) > MAX_DEPTH) ? 9'(MAX_DEPTH) : grid_depth;

  assign inside_now = ({1'b0, item_word.col_x} < lim_w) && ({1'b0, item_word.col_z} < lim_d);
  assign accept     = item_valid && !item_stall;

  assign xa    = XW'(x_reg);
  assign za    = ZW'(z_reg);
  assign has_w = x_reg != 8'd0;
  assign has_e = ({1'b0, x_reg} + 9'd1) < lim_w;
  assign has_n = z_reg != 8'd0;
  assign has_s = ({1'b0, z_reg} + 9'd1) < lim_d;

  assign nb_height = 8'(mem_rdata);
  assign diff      = (g_reg > nb_height) ? g_reg - nb_height : nb_height - g_reg;
  assign nb_steep  = diff >= 8'd2;

  hvc_height_mem #(
    .AW(AW),
    .DW(HEIGHT_BITS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr({za, xa}),
    .wdata(HEIGHT_BITS'(q_height)),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  hvc_quantize #(
    .HEIGHT_BITS(HEIGHT_BITS)
  ) u_quant (
    .clk            (clk),
    .capture        (accept),
    .elevation      (item_word.elevation),
    .vertical_levels(vertical_levels),
    .water_level    (water_level),
    .height         (q_height)
  );

  always_comb begin
    cls.height          = g_reg;
    cls.level_y         = y_reg;
    cls.vertical_levels = vertical_levels;
    cls.water_level     = water_level;
    cls.water_enabled   = water_enabled;
    cls.steep           = steep_reg;
  end

  hvc_classify u_cls (
    .cls     (cls),
    .material(cls_material)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (item_word.operation == OP_LOAD) begin
            state_next = ST_LOAD;
          end else if (inside_now) begin
            state_next = ST_RD_C;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_LOAD: state_next = ST_DONE;
      ST_RD_C: state_next = ST_RD_W;
      ST_RD_W: state_next = ST_RD_E;
      ST_RD_E: state_next = ST_RD_N;
      ST_RD_N: state_next = ST_RD_S;
      ST_RD_S: state_next = ST_EVAL;
      ST_EVAL: state_next = ST_DONE;
      ST_DONE: begin
        if (result_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    item_stall  = 1'b1;
    mem_we      = 1'b0;
    mem_raddr   = {za, xa};
    result_load = 1'b0;
    unique case (state)
      ST_IDLE: item_stall = 1'b0;
      ST_LOAD: mem_we = inside_reg;
      ST_RD_C: mem_raddr = {za, xa};
      ST_RD_W: mem_raddr = {za, xa - XW'(1)};
      ST_RD_E: mem_raddr = {za, xa + XW'(1)};
      ST_RD_N: mem_raddr = {za - ZW'(1), xa};
      ST_RD_S: mem_raddr = {za + ZW'(1), xa};
      ST_EVAL: mem_raddr = {za, xa};
      ST_DONE: result_load = !result_valid || !result_stall;
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      grid_width      <= RST_GRID_WIDTH;
      grid_depth      <= RST_GRID_DEPTH;
      vertical_levels <= RST_VERTICAL_LEVELS;
      water_level     <= RST_WATER_LEVEL;
      water_enabled   <= RST_WATER_ENABLED;
      max_height      <= 8'd0;
      result_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_GRID_WIDTH:      grid_width      <= cfg_data;
          CFG_GRID_DEPTH:      grid_depth      <= cfg_data;
          CFG_VERTICAL_LEVELS: vertical_levels <= cfg_data[7:0];
          CFG_WATER_LEVEL:     water_level     <= cfg_data[7:0];
          CFG_WATER_ENABLED:   water_enabled   <= cfg_data[0];
          default: ;
        endcase
      end
      if (state == ST_LOAD && inside_reg && q_height > max_height) begin
        max_height <= q_height;
      end
      if (result_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign top = (g_reg > water_level) ? g_reg : water_level;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_reg     <= item_word.operation;
      x_reg      <= item_word.col_x;
      z_reg      <= item_word.col_z;
      y_reg      <= item_word.level_y;
      inside_reg <= inside_now;
      steep_reg  <= 1'b0;
      g_reg      <= 8'd0;
    end
    case (state)
      ST_LOAD: g_reg <= inside_reg ? q_height : 8'd0;
      ST_RD_W: g_reg <= nb_height;
      ST_RD_E: if (has_w && nb_steep) steep_reg <= 1'b1;
      ST_RD_N: if (has_e && nb_steep) steep_reg <= 1'b1;
      ST_RD_S: if (has_n && nb_steep) steep_reg <= 1'b1;
      ST_EVAL: if (has_s && nb_steep) steep_reg <= 1'b1;
      default: ;
    endcase
    if (result_load) begin
      result_word.material       <= (op_reg == OP_QUERY && inside_reg) ? cls_material
                                                                        : MAT_AIR;
      result_word.surface_height <= g_reg;
      result_word.water_top      <= inside_reg ? top : 8'd0;
      result_word.steep          <= steep_reg;
      result_word.highest_ground <= max_height;
      result_word.inside_grid    <= inside_reg;
    end
  end

endmodule
